>>> src/bffra_pkg.sv
// Shared constants, state encoding and controller/datapath bundles for the run allocator.
package bffra_pkg;

	localparam int MAP_BITS_DEF = 4096;
	localparam int WORD_BITS    = 8;
	localparam int WORD_SHIFT   = 3;
	localparam int CFG_W        = 13;
	localparam int LEN_W        = 13;
	localparam int START_W      = 12;
	localparam int NUM_REGS     = 2;
	localparam int REG_IDX_W    = 1;

	localparam logic [REG_IDX_W-1:0] REG_RESERVED_COUNT = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_USABLE_END     = 1'd1;

	localparam logic [CFG_W-1:0] RESERVED_COUNT_RST = 13'd3;
	localparam logic [CFG_W-1:0] USABLE_END_RST     = 13'd4096;

	localparam logic MODE_INIT  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN0,
		ST_SCAN,
		ST_CLR_RD,
		ST_CLR_WR,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic item_ld;
		logic init_wr;
		logic scan_rd;
		logic scan_eval;
		logic clr_setup;
		logic clr_wr;
		logic res_init;
		logic res_hit;
		logic res_miss;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic zero_len;
		logic scan_last;
		logic ptr_last;
		logic clr_last;
	} dp_sts_t;

endpackage

>>> src/bffra_if.sv
// Valid/ready channel interfaces for allocation requests and results.
interface bffra_req_if;
	import bffra_pkg::*;

	logic             valid;
	logic             ready;
	logic             mode;
	logic [LEN_W-1:0] run_length;

	modport source (output valid, output mode, output run_length, input ready);
	modport sink   (input valid, input mode, input run_length, output ready);
endinterface

interface bffra_rsp_if;
	import bffra_pkg::*;

	logic               valid;
	logic               ready;
	logic               found;
	logic [START_W-1:0] start_index;

	modport source (output valid, output found, output start_index, input ready);
	modport sink   (input valid, input found, input start_index, output ready);
endinterface

>>> src/bffra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bffra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/bffra_ctrl.sv
// Controller state machine sequencing map rebuild, run scan and run clearing.
module bffra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_mode,
	input  logic              out_free,
	input  bffra_pkg::dp_sts_t sts,
	output bffra_pkg::dp_cmd_t cmd,
	output logic              idle,
	output logic              out_load
);
	import bffra_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		idle     = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					cmd.item_ld = 1'b1;
					state_d     = (in_mode == MODE_INIT) ? ST_INIT : ST_SCAN0;
				end
			end
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.ptr_last) begin
					cmd.res_init = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_SCAN0: begin
				cmd.scan_rd = 1'b1;
				state_d     = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_eval = 1'b1;
				if (sts.hit) begin
					cmd.res_hit = 1'b1;
					if (sts.zero_len) begin
						state_d = ST_DONE;
					end else begin
						cmd.clr_setup = 1'b1;
						state_d       = ST_CLR_RD;
					end
				end else if (sts.scan_last) begin
					cmd.res_miss = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			ST_CLR_RD: begin
				state_d = ST_CLR_WR;
			end
			ST_CLR_WR: begin
				cmd.clr_wr = 1'b1;
				state_d    = sts.clr_last ? ST_DONE : ST_CLR_RD;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

>>> src/bffra_dp.sv
// Datapath: free map memory, word pointer, run tracking and result registers.
module bffra_dp #(
	parameter int MAP_BITS = bffra_pkg::MAP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bffra_pkg::dp_cmd_t           cmd,
	output bffra_pkg::dp_sts_t           sts,
	input  logic [bffra_pkg::CFG_W-1:0]  reserved_count,
	input  logic [bffra_pkg::CFG_W-1:0]  usable_end,
	input  logic [bffra_pkg::LEN_W-1:0]  run_length,
	output logic                         found,
	output logic [bffra_pkg::START_W-1:0] start_index
);
	import bffra_pkg::*;

	localparam int DEPTH = MAP_BITS / WORD_BITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAP_BITS);
	localparam int CW    = $clog2(MAP_BITS + 1);
	localparam int NW    = (CW > LEN_W) ? CW : LEN_W;

	logic                 live_q;
	logic [AW-1:0]        ptr_q;
	logic [AW-1:0]        rd_addr_q;
	logic [LEN_W-1:0]     len_q;
	logic [NW-1:0]        run_q;
	logic [IW-1:0]        run_start_q;
	logic [IW-1:0]        hit_start_q;
	logic [IW-1:0]        hit_end_q;
	logic                 found_q;
	logic [IW-1:0]        start_q;

	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] init_word;
	logic [WORD_BITS-1:0] clr_word;
	logic [WORD_BITS-1:0] wdata;
	logic                 we;
	logic [NW-1:0]        need;
	logic [NW-1:0]        run_d;
	logic [IW-1:0]        run_start_d;
	logic                 hit;
	logic [IW-1:0]        hit_pos;
	logic [IW+START_W-1:0] start_ext;

	assign word = live_q ? ram_rdata : '0;
	assign need = (len_q == '0) ? NW'(1) : NW'(len_q);

	always_comb begin
		logic [IW-1:0] pos;
		logic [IW-1:0] wpos;
		run_d       = run_q;
		run_start_d = run_start_q;
		hit         = 1'b0;
		hit_pos     = '0;
		init_word   = '0;
		clr_word    = word;
		for (int b = 0; b < WORD_BITS; b++) begin
			pos  = {rd_addr_q, WORD_SHIFT'(b)};
			wpos = {ptr_q, WORD_SHIFT'(b)};
			init_word[b] = (NW'(wpos) >= NW'(reserved_count)) &&
				(NW'(wpos) < NW'(usable_end));
			if ((pos >= hit_start_q) && (pos <= hit_end_q)) begin
				clr_word[b] = 1'b0;
			end
			if (!hit) begin
				if (word[b]) begin
					if (run_d == '0) begin
						run_start_d = pos;
					end
					run_d = run_d + NW'(1);
					if (run_d >= need) begin
						hit     = 1'b1;
						hit_pos = pos;
					end
				end else begin
					run_d = '0;
				end
			end
		end
	end

	assign we    = cmd.init_wr || cmd.clr_wr;
	assign wdata = cmd.init_wr ? init_word : clr_word;

	bffra_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (ptr_q),
		.wdata (wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			ptr_q  <= '0;
		end else begin
			if (cmd.init_wr) begin
				live_q <= 1'b1;
			end
			if (cmd.item_ld) begin
				ptr_q <= '0;
			end else if (cmd.clr_setup) begin
				ptr_q <= run_start_d[IW-1:WORD_SHIFT];
			end else if (cmd.init_wr || cmd.scan_rd || cmd.clr_wr) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= ptr_q;
		if (cmd.item_ld) begin
			len_q <= run_length;
			run_q <= '0;
		end else if (cmd.scan_eval) begin
			run_q       <= run_d;
			run_start_q <= run_start_d;
		end
		if (cmd.res_hit) begin
			hit_start_q <= run_start_d;
			hit_end_q   <= hit_pos;
			found_q     <= 1'b1;
			start_q     <= run_start_d;
		end else if (cmd.res_init || cmd.res_miss) begin
			found_q <= cmd.res_init;
			start_q <= '0;
		end
	end

	assign sts.hit       = hit;
	assign sts.zero_len  = (len_q == '0);
	assign sts.scan_last = (rd_addr_q == AW'(DEPTH - 1));
	assign sts.ptr_last  = (ptr_q == AW'(DEPTH - 1));
	assign sts.clr_last  = (ptr_q == hit_end_q[IW-1:WORD_SHIFT]);

	assign start_ext   = {{START_W{1'b0}}, start_q};
	assign found       = found_q;
	assign start_index = start_ext[START_W-1:0];
endmodule

>>> src/bitmap_first_fit_run_allocator_unit.sv
// Init rewrites every map word; an allocation scans 8 map bits per cycle to find a run,
// then clears a found run of nonzero length word by word.
// One item at a time; the scan over the word-wide map memory sets the rate.
// A finished result waits in the output register while the next item is taken.
// Reset: registers return to reserved_count = 3, usable_end = 4096; the map reads as all
// used until the first init item, with no clearing pass.
module bitmap_first_fit_run_allocator_unit #(
	parameter int MAP_BITS = bffra_pkg::MAP_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bffra_req_if.sink                      req,
	bffra_rsp_if.source                    rsp,
	input  logic                           wr_en,
	input  logic [bffra_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [bffra_pkg::CFG_W-1:0]    wr_data
);
	import bffra_pkg::*;

	logic               idle;
	logic               in_fire;
	logic               out_load;
	logic               out_free;
	dp_cmd_t            cmd;
	dp_sts_t            sts;
	logic [CFG_W-1:0]   reserved_count_q;
	logic [CFG_W-1:0]   usable_end_q;
	logic               dp_found;
	logic [START_W-1:0] dp_start;
	logic               out_valid_q;
	logic               found_q;
	logic [START_W-1:0] start_q;

	assign req.ready = idle;
	assign in_fire   = req.valid && idle;
	assign out_free  = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_count_q <= RESERVED_COUNT_RST;
			usable_end_q     <= USABLE_END_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RESERVED_COUNT: reserved_count_q <= wr_data;
				REG_USABLE_END:     usable_end_q     <= wr_data;
				default: ;
			endcase
		end
	end

	bffra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_mode  (req.mode),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle),
		.out_load (out_load)
	);

	bffra_dp #(
		.MAP_BITS (MAP_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.reserved_count (reserved_count_q),
		.usable_end     (usable_end_q),
		.run_length     (req.run_length),
		.found          (dp_found),
		.start_index    (dp_start)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q <= dp_found;
			start_q <= dp_start;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.start_index = start_q;
endmodule

>>> bench/bitmap_first_fit_run_allocator_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the first-fit run allocator with a live free-map model.
module bitmap_first_fit_run_allocator_unit_tb;
	import bffra_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 40;

	typedef struct packed {
		logic               found;
		logic [START_W-1:0] start_index;
	} alloc_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	bffra_req_if req_ch ();
	bffra_rsp_if rsp_ch ();

	bitmap_first_fit_run_allocator_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	bit            model_free_map [MAP_BITS_DEF];
	int unsigned   model_reserved;
	int unsigned   model_end;
	alloc_result_t pending_results [$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int mismatches;
	int idle_cycles;
	int rebuilds_sent;
	int fits_seen;
	int refusals_seen;
	int reg_writes;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int count_free();
		int n;
		n = 0;
		for (int i = 0; i < MAP_BITS_DEF; i++)
			n += model_free_map[i];
		return n;
	endfunction

	function automatic alloc_result_t predict_allocation(logic mode, logic [LEN_W-1:0] len);
		alloc_result_t res;
		int lo;
		int hi;
		int i;
		int j;
		bit hit;
		res = '0;
		hit = 1'b0;
		i = 0;
		if (mode == MODE_INIT) begin
			lo = (model_reserved > MAP_BITS_DEF) ? MAP_BITS_DEF : model_reserved;
			hi = (model_end > MAP_BITS_DEF) ? MAP_BITS_DEF : model_end;
			for (int k = 0; k < MAP_BITS_DEF; k++)
				model_free_map[k] = (k >= lo && k < hi);
			res.found = 1'b1;
			return res;
		end
		if (len <= MAP_BITS_DEF) begin
			while (i < MAP_BITS_DEF && !hit) begin
				if (!model_free_map[i]) begin
					i++;
				end else begin
					j = i;
					while (j < MAP_BITS_DEF && model_free_map[j])
						j++;
					if (j - i >= len)
						hit = 1'b1;
					else
						i = j;
				end
			end
		end
		if (hit) begin
			for (int k = i; k < i + len; k++)
				model_free_map[k] = 1'b0;
			res.found       = 1'b1;
			res.start_index = START_W'(i);
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	task automatic send_request(input logic mode, input int len);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= mode;
		req_ch.run_length <= LEN_W'(len);
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_results.push_back(predict_allocation(mode, LEN_W'(len)));
		if (mode == MODE_INIT)
			rebuilds_sent++;
	endtask

	task automatic wait_until_drained();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_register(input logic [REG_IDX_W-1:0] idx, input int value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= CFG_W'(value);
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_RESERVED_COUNT)
			model_reserved = value & 16'h1FFF;
		else
			model_end = value & 16'h1FFF;
		reg_writes++;
	endtask

	task automatic set_bounds(input int lo, input int hi);
		wait_until_drained();
		program_register(REG_RESERVED_COUNT, lo);
		program_register(REG_USABLE_END, hi);
	endtask

	function automatic int pick_run_length();
		int r;
		int avail;
		r = $urandom_range(99);
		avail = count_free();
		if (r < 5)
			return 0;
		else if (r < 60)
			return $urandom_range(1, 8);
		else if (r < 78)
			return $urandom_range(9, 64);
		else if (r < 84)
			return $urandom_range(65, 512);
		else if (r < 88)
			return (avail == 0) ? 1 : avail;
		else if (r < 92)
			return avail + 1;
		else if (r < 96)
			return $urandom_range(0, 8191);
		return $urandom_range(513, MAP_BITS_DEF);
	endfunction

	task automatic test_before_init();
		send_request(MODE_ALLOC, 1);
		send_request(MODE_ALLOC, 0);
	endtask

	task automatic test_directed_runs();
		send_request(MODE_INIT, 0);
		send_request(MODE_ALLOC, 0);
		send_request(MODE_ALLOC, 1);
		send_request(MODE_ALLOC, 0);
		send_request(MODE_ALLOC, 13);
		send_request(MODE_ALLOC, MAP_BITS_DEF + 1);
		send_request(MODE_ALLOC, 8191);
		send_request(MODE_ALLOC, MAP_BITS_DEF);
		send_request(MODE_ALLOC, count_free());
		send_request(MODE_ALLOC, 1);
		send_request(MODE_ALLOC, 0);
		send_request(MODE_INIT, 0);
		send_request(MODE_ALLOC, MAP_BITS_DEF - 3);
	endtask

	task automatic test_register_extremes();
		set_bounds(0, MAP_BITS_DEF);
		send_request(MODE_INIT, 0);
		send_request(MODE_ALLOC, MAP_BITS_DEF);
		send_request(MODE_ALLOC, 0);
		set_bounds(MAP_BITS_DEF, 8191);
		send_request(MODE_INIT, 0);
		send_request(MODE_ALLOC, 0);
		set_bounds(8191, 0);
		send_request(MODE_INIT, 0);
		send_request(MODE_ALLOC, 1);
		set_bounds(100, 50);
		send_request(MODE_INIT, 0);
		send_request(MODE_ALLOC, 1);
		set_bounds(MAP_BITS_DEF - 1, MAP_BITS_DEF);
		send_request(MODE_INIT, 8191);
		send_request(MODE_ALLOC, 1);
		send_request(MODE_ALLOC, 1);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int items);
		int lo;
		int hi;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int seg = 0; seg < 3; seg++) begin
			case ($urandom_range(7))
				0: lo = 0;
				1: lo = 8191;
				2: lo = MAP_BITS_DEF;
				3: lo = $urandom_range(MAP_BITS_DEF - 200, MAP_BITS_DEF);
				default: lo = $urandom_range(0, 200);
			endcase
			case ($urandom_range(7))
				0: hi = MAP_BITS_DEF;
				1: hi = 8191;
				2: hi = $urandom_range(0, 8191);
				3: hi = lo + $urandom_range(0, 64);
				default: hi = $urandom_range(1024, MAP_BITS_DEF);
			endcase
			set_bounds(lo, hi);
			send_request(MODE_INIT, $urandom_range(0, 8191));
			for (int n = 0; n < items / 3; n++) begin
				if ($urandom_range(99) < 4 || (count_free() == 0 && $urandom_range(3) != 0))
					send_request(MODE_INIT, $urandom_range(0, 8191));
				else
					send_request(MODE_ALLOC, pick_run_length());
			end
		end
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unrequested beat", 0, 1);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.found !== want.found)
					report_mismatch("found", want.found, rsp_ch.found);
				if (rsp_ch.start_index !== want.start_index)
					report_mismatch("start_index", want.start_index, rsp_ch.start_index);
				if (want.found)
					fits_seen++;
				else
					refusals_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		model_reserved     = RESERVED_COUNT_RST;
		model_end          = USABLE_END_RST;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		rebuilds_sent      = 0;
		reg_writes         = 0;
		arst_n            <= 1'b0;
		wr_en             <= 1'b0;
		wr_index          <= '0;
		wr_data           <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.mode       <= MODE_INIT;
		req_ch.run_length <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_before_init();
		test_directed_runs();
		test_register_extremes();
		test_random_traffic(0, 0, 120);
		test_random_traffic(51, 0, 120);
		test_random_traffic(0, 51, 120);
		test_random_traffic(31, 31, 120);

		wait_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d rebuilds, %0d fitted and %0d refused requests, %0d reg writes",
			rebuilds_sent, fits_seen - rebuilds_sent, refusals_seen, reg_writes);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
src/bffra_pkg.sv
src/bffra_if.sv
src/bffra_ram.sv
src/bffra_ctrl.sv
src/bffra_dp.sv
src/bitmap_first_fit_run_allocator_unit.sv
bench/bitmap_first_fit_run_allocator_unit_tb.sv
